/* src/mtsc_pkg.sv */
// Package for the MIDI to speech-chip command core: payload types, event codes,
// register selects, divide-by-constant reciprocals and the phoneme code table.
// No dependencies.
package mtsc_pkg;

	// Event codes
	localparam logic [3:0] OpNoteOff = 4'd8;
	localparam logic [3:0] OpNoteOn  = 4'd9;
	localparam logic [3:0] OpCtrl    = 4'd11;
	localparam logic [3:0] OpBend    = 4'd14;

	localparam logic [3:0] ChanSpeech = 4'd0;
	localparam logic [3:0] ChanOsc    = 4'd1;
	localparam logic [6:0] CtrlFilter = 7'd1;

	// Speech chip register selects
	localparam logic [2:0] RegPhoneme   = 3'd0;
	localparam logic [2:0] RegAmplitude = 3'd3;
	localparam logic [2:0] RegFilter    = 3'd4;

	localparam logic TargetSpeech = 1'b0;
	localparam logic TargetOsc    = 1'b1;

	localparam logic [7:0]  DurationCode  = 8'hC0;
	localparam logic [7:0]  AmpBase       = 8'h30;
	localparam logic [7:0]  FilterBase    = 8'd200;
	localparam logic [15:0] OscOctaveWord = 16'hA000;

	// Note clamp window for the phoneme lookup
	localparam logic [6:0] NoteLow  = 7'd36;
	localparam logic [6:0] NoteHigh = 7'd93;
	localparam int unsigned RomDepth = 58;

	// value*15/127 for value < 2^11 after the scale: rounded-up reciprocal, shift 18
	localparam int unsigned VelDiv     = 127;
	localparam int unsigned AmpShift   = 18;
	localparam int unsigned AmpRecip   = ((1 << AmpShift) + VelDiv - 1) / VelDiv;
	localparam logic [21:0] AmpMul     = 22'(15 * AmpRecip);
	// value*51/127 for products < 2^13: shift 20
	localparam int unsigned FiltShift  = 20;
	localparam int unsigned FiltRecip  = ((1 << FiltShift) + VelDiv - 1) / VelDiv;
	localparam logic [25:0] FiltMul    = 26'(51 * FiltRecip);

	// Pitch bend: dac = 1023 -/+ |v - 16288| * 1015 / 16188, dividend < 2^24
	localparam logic [13:0] BendCenter = 14'd16288;
	localparam logic [23:0] BendScale  = 24'd1015;
	localparam longint unsigned BendDiv   = 16188;
	localparam int unsigned     BendShift = 38;
	localparam longint unsigned BendRecip =
		((64'd1 << BendShift) + BendDiv - 1) / BendDiv;
	localparam logic [48:0] BendRecipW = 49'(BendRecip);
	localparam logic [10:0] DacMid     = 11'd1023;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] channel;
		logic [6:0] data_first;
		logic [6:0] data_second;
	} in_t;

	typedef struct packed {
		logic        target;
		logic [2:0]  speech_register;
		logic [7:0]  speech_value;
		logic [15:0] oscillator_word;
		logic        busy_res;
		logic        last;
	} out_t;

	// One classified event: how many results and their payloads
	typedef struct packed {
		logic [1:0] count;
		out_t       first;
		out_t       second;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [5:0] phoneme_code(input logic [5:0] idx);
		logic [5:0] code;
		unique case (idx)
			6'd0:  code = 6'h16;  6'd1:  code = 6'h3D;  6'd2:  code = 6'h14;
			6'd3:  code = 6'h3C;  6'd4:  code = 6'h11;  6'd5:  code = 6'h13;
			6'd6:  code = 6'h3B;  6'd7:  code = 6'h10;  6'd8:  code = 6'h3B;
			6'd9:  code = 6'h0E;  6'd10: code = 6'h08;  6'd11: code = 6'h1C;
			6'd12: code = 6'h3E;  6'd13: code = 6'h0A;  6'd14: code = 6'h07;
			6'd15: code = 6'h01;  6'd16: code = 6'h06;  6'd17: code = 6'h04;
			6'd18: code = 6'h39;  6'd19: code = 6'h37;  6'd20: code = 6'h20;
			6'd21: code = 6'h38;  6'd22: code = 6'h1F;  6'd23: code = 6'h2C;
			6'd24: code = 6'h2D;  6'd25: code = 6'h31;  6'd26: code = 6'h32;
			6'd27: code = 6'h2F;  6'd28: code = 6'h30;  6'd29: code = 6'h34;
			6'd30: code = 6'h33;  6'd31: code = 6'h2C;  6'd32: code = 6'h24;
			6'd33: code = 6'h27;  6'd34: code = 6'h25;  6'd35: code = 6'h28;
			6'd36: code = 6'h29;  6'd37: code = 6'h26;  6'd38: code = 6'h00;
			6'd39: code = 6'h12;  6'd40: code = 6'h18;  6'd41: code = 6'h0C;
			6'd42: code = 6'h3A;  6'd43: code = 6'h05;  6'd44: code = 6'h03;
			6'd45: code = 6'h2A;  6'd46: code = 6'h2B;  6'd47: code = 6'h2E;
			6'd48: code = 6'h22;  6'd49: code = 6'h21;  6'd50: code = 6'h3F;
			6'd51: code = 6'h36;  6'd52: code = 6'h35;  6'd53: code = 6'h1D;
			6'd54: code = 6'h1E;  6'd55: code = 6'h23;  6'd56: code = 6'h26;
			6'd57: code = 6'h2B;
			default: code = 6'h00;
		endcase
		return code;
	endfunction

endpackage

/* src/mtsc_front.sv */
// Front end: accepts MIDI events, tracks held note and speaking flag, and
// classifies each event into a command of up to two results over two stages.
// Depends on mtsc_pkg.
module mtsc_front import mtsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   event_valid,
	output logic   event_stall,
	input  in_t    event_data,
	output logic   push,
	output cmd_t   push_data,
	input  qstat_t qstat
);

	logic        v_s1, v_s2;
	cmd_t        cmd_s1, cmd_s2;
	logic        bend_s1, bend_s2;
	logic        neg_s1, neg_s2;
	logic [23:0] prod_s1;
	logic [9:0]  quot_s2;
	logic [6:0]  held_note_q;
	logic        speaking_q;

	logic        en, accept;
	logic [6:0]  nxt_held;
	logic        nxt_speaking;
	cmd_t        cmd_c;
	logic        bend_c;
	logic [21:0] amp_prod;
	logic [25:0] filt_prod;
	logic [7:0]  amp_val, filt_val;
	logic [6:0]  note_clamped;
	logic [5:0]  rom_idx;
	logic [13:0] bend_raw, bend_mag;
	logic        bend_neg;
	logic [48:0] bend_full;
	logic [10:0] dac;

	// Stall only when a result-bearing command waits on a full queue
	assign en          = !(v_s2 && (cmd_s2.count != 2'd0) && qstat.full);
	assign event_stall = !en;
	assign accept      = event_valid && en;
	assign push        = v_s2 && (cmd_s2.count != 2'd0) && !qstat.full;

	assign amp_prod  = 22'(event_data.data_second) * AmpMul;
	assign amp_val   = AmpBase + 8'(amp_prod[21:AmpShift]);
	assign filt_prod = 26'(event_data.data_second) * FiltMul;
	assign filt_val  = FilterBase + 8'(filt_prod[25:FiltShift]);

	always_comb begin
		if (event_data.data_first < NoteLow) begin
			note_clamped = NoteLow;
		end else if (event_data.data_first > NoteHigh) begin
			note_clamped = NoteHigh;
		end else begin
			note_clamped = event_data.data_first;
		end
	end
	assign rom_idx = 6'(note_clamped - NoteLow);

	assign bend_raw = {event_data.data_second, event_data.data_first};
	assign bend_neg = bend_raw < BendCenter;
	assign bend_mag = bend_neg ? (BendCenter - bend_raw) : (bend_raw - BendCenter);

	always_comb begin
		nxt_held     = held_note_q;
		nxt_speaking = speaking_q;
		cmd_c        = '0;
		bend_c       = 1'b0;
		unique case (event_data.op)
			OpNoteOn: begin
				if (event_data.channel == ChanSpeech) begin
					nxt_held                     = event_data.data_first;
					nxt_speaking                 = 1'b1;
					cmd_c.count                  = 2'd2;
					cmd_c.first.target           = TargetSpeech;
					cmd_c.first.speech_register  = RegAmplitude;
					cmd_c.first.speech_value     = amp_val;
					cmd_c.second.target          = TargetSpeech;
					cmd_c.second.speech_register = RegPhoneme;
					cmd_c.second.speech_value    = DurationCode | {2'b00, phoneme_code(rom_idx)};
					cmd_c.second.last            = 1'b1;
				end else if (event_data.channel == ChanOsc) begin
					cmd_c.count                 = 2'd1;
					cmd_c.first.target          = TargetOsc;
					cmd_c.first.oscillator_word =
						OscOctaveWord | {4'b0000, event_data.data_first, 5'b00000};
					cmd_c.first.last            = 1'b1;
				end
			end
			OpNoteOff: begin
				if (event_data.channel == ChanSpeech && event_data.data_first == held_note_q) begin
					nxt_speaking                = 1'b0;
					cmd_c.count                 = 2'd1;
					cmd_c.first.target          = TargetSpeech;
					cmd_c.first.speech_register = RegPhoneme;
					cmd_c.first.speech_value    = DurationCode;
					cmd_c.first.last            = 1'b1;
				end
			end
			OpCtrl: begin
				if (event_data.data_first == CtrlFilter) begin
					cmd_c.count                 = 2'd1;
					cmd_c.first.target          = TargetSpeech;
					cmd_c.first.speech_register = RegFilter;
					cmd_c.first.speech_value    = filt_val;
					cmd_c.first.last            = 1'b1;
				end
			end
			OpBend: begin
				// word filled in at stage two once the quotient is known
				bend_c             = 1'b1;
				cmd_c.count        = 2'd1;
				cmd_c.first.target = TargetOsc;
				cmd_c.first.last   = 1'b1;
			end
			default: begin
			end
		endcase
		cmd_c.first.busy_res  = nxt_speaking;
		cmd_c.second.busy_res = nxt_speaking;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			held_note_q <= '0;
			speaking_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				held_note_q <= nxt_held;
				speaking_q  <= nxt_speaking;
			end
		end
	end

	assign bend_full = 49'(prod_s1) * BendRecipW;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cmd_c;
			bend_s1 <= bend_c;
			neg_s1  <= bend_neg;
			prod_s1 <= 24'(bend_mag) * BendScale;
			cmd_s2  <= cmd_s1;
			bend_s2 <= bend_s1;
			neg_s2  <= neg_s1;
			quot_s2 <= 10'(bend_full >> BendShift);
		end
	end

	assign dac = neg_s2 ? (DacMid - 11'(quot_s2)) : (DacMid + 11'(quot_s2));

	always_comb begin
		push_data = cmd_s2;
		if (bend_s2) begin
			push_data.first.oscillator_word = OscOctaveWord | {3'b000, dac, 2'b00};
		end
	end

`ifndef SYNTH
	a_stall_needs_s2: assert property (@(posedge clk) disable iff (!arst_n)
		event_stall |-> v_s2 && qstat.full)
		else $error("front stalls without a blocked command");
`endif

endmodule

/* src/mtsc_queue.sv */
// Command queue between front and back: a small register FIFO of classified
// commands. Depends on mtsc_pkg.
module mtsc_queue import mtsc_pkg::*; #(
	parameter int Depth = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_data,
	input  logic   pop,
	output cmd_t   head,
	output qstat_t qstat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign qstat.full  = (count_q == CntW'(Depth));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");
	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("command pushed into a full queue");
`endif

endmodule

/* src/mtsc_back.sv */
// Back end: takes commands from the queue and sends their results one per
// cycle while results are not stalled, through a registered output stage. Depends on mtsc_pkg.
module mtsc_back import mtsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   head,
	input  qstat_t qstat,
	output logic   pop,
	output logic   result_valid,
	input  logic   result_stall,
	output out_t   result_data
);

	logic phase_q;
	logic out_v_q;
	out_t out_q;
	logic load;
	out_t sel;

	assign load = !out_v_q || !result_stall;
	assign sel  = phase_q ? head.second : head.first;
	assign pop  = load && !qstat.empty && sel.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= !qstat.empty;
			if (!qstat.empty) begin
				// advance to the second result or back to the first of the next
				phase_q <= !sel.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			out_q <= sel;
		end
	end

	assign result_valid = out_v_q;
	assign result_data  = out_q;

`ifndef SYNTH
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result_data.last |=> result_valid)
		else $error("second result of an event did not follow");
	a_first_is_amp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.last |->
			result_data.target == TargetSpeech && result_data.speech_register == RegAmplitude)
		else $error("non-final result is not the amplitude write");
`endif

endmodule

/* src/midi_to_speech_chip_commands_core.sv */
// Top level of the MIDI to speech-chip command core: front classifier, command
// queue and result back end. Depends on mtsc_pkg, mtsc_front, mtsc_queue, mtsc_back.
//
//  channel   direction  handshake            payload
//  event     in         event_valid/stall    in_t  event_data
//  result    out        result_valid/stall   out_t result_data
//
// The front takes one event per cycle unless it stalls; its two stages hold the bend divide.
// The back sends one result per cycle unless results are stalled, so a note-on's two results
// leave back to back; the first passes both front stages, the queue and the output register.
// Reset clears held note, speaking flag, pipeline valids and the queue.
// A stalled result holds the back; the queue absorbs QueueDepth commands before
// the front stalls events.
module midi_to_speech_chip_commands_core import mtsc_pkg::*; #(
	parameter int QueueDepth = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic event_valid,
	output logic event_stall,
	input  in_t  event_data,
	output logic result_valid,
	input  logic result_stall,
	output out_t result_data
);

	logic   push, pop;
	cmd_t   push_data, head;
	qstat_t qstat;

	mtsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_data  (event_data),
		.push        (push),
		.push_data   (push_data),
		.qstat       (qstat)
	);

	mtsc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	mtsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
